>>> hdl/sfdl_pkg.sv
package sfdl_pkg;

	localparam int RING_DEPTH_DEF = 131072;
	localparam int SAMPLE_W = 24;
	localparam int DTGT_W = 25;
	localparam int LVL_W = 33;
	localparam int CFG_IDX_W = 3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] in_left;
		logic signed [SAMPLE_W-1:0] in_right;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_left;
		logic signed [SAMPLE_W-1:0] out_right;
	} out_word_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_TARGET = 3'd0,
		REG_FB_TARGET    = 3'd1,
		REG_MIX_TARGET   = 3'd2,
		REG_DELAY_RAMP   = 3'd3,
		REG_LEVEL_RAMP   = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD_IN,
		OP_DIV_DELAY,
		OP_DIV_FB,
		OP_DIV_MIX,
		OP_SET_DINC,
		OP_SET_FINC,
		OP_SET_MINC,
		OP_ADVANCE,
		OP_RD_A,
		OP_RD_B,
		OP_INTERP,
		OP_FBMUL,
		OP_WRITE,
		OP_MIX,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   ch;
	} dp_cmd_t;

	typedef struct packed {
		logic delay_chg;
		logic level_chg;
		logic div_done;
		logic out_free;
	} dp_sts_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RETGT,
		S_DDIV,
		S_LCHK,
		S_FDIV,
		S_MSTART,
		S_MDIV,
		S_ADV,
		S_RDA,
		S_RDB,
		S_INTERP,
		S_FBMUL,
		S_WRITE,
		S_MIX,
		S_FIN
	} ctrl_state_t;

	function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [43:0] v);
		logic signed [43:0] hi;
		logic signed [43:0] lo;
		hi = 44'sd8388607;
		lo = -44'sd8388608;
		if (v > hi)
			return hi[SAMPLE_W-1:0];
		else if (v < lo)
			return lo[SAMPLE_W-1:0];
		else
			return v[SAMPLE_W-1:0];
	endfunction

endpackage

>>> hdl/sfdl_div.sv
module sfdl_div #(
	parameter int QW = 41
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [QW-1:0] num,
	input  logic [15:0]          den,
	output logic                 done,
	output logic signed [QW-1:0] quo
);
	localparam int CW = $clog2(QW + 1);

	logic [QW-1:0] nq_q;
	logic [15:0]   rem_q;
	logic [15:0]   den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          neg_q;
	logic          done_q;
	logic [16:0]   trial;
	logic          qbit;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, nq_q[QW-1]};
		qbit  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num[QW-1] ? QW'(-num) : num;
			neg_q <= num[QW-1];
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= qbit ? 16'(trial - {1'b0, den_q}) : trial[15:0];
			nq_q  <= {nq_q[QW-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(nq_q) : $signed(nq_q);

endmodule

>>> hdl/sfdl_ctrl.sv
module sfdl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  sfdl_pkg::dp_sts_t sts,
	output sfdl_pkg::dp_cmd_t cmd
);
	import sfdl_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        ch_q;
	logic        ch_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ch_d    = ch_q;
		cmd.op  = OP_NONE;
		cmd.ch  = ch_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD_IN;
					state_d = S_RETGT;
				end
			end
			S_RETGT: begin
				if (sts.delay_chg) begin
					cmd.op  = OP_DIV_DELAY;
					state_d = S_DDIV;
				end else begin
					state_d = S_LCHK;
				end
			end
			S_DDIV: begin
				if (sts.div_done) begin
					cmd.op  = OP_SET_DINC;
					state_d = S_LCHK;
				end
			end
			S_LCHK: begin
				if (sts.level_chg) begin
					cmd.op  = OP_DIV_FB;
					state_d = S_FDIV;
				end else begin
					state_d = S_ADV;
				end
			end
			S_FDIV: begin
				if (sts.div_done) begin
					cmd.op  = OP_SET_FINC;
					state_d = S_MSTART;
				end
			end
			S_MSTART: begin
				cmd.op  = OP_DIV_MIX;
				state_d = S_MDIV;
			end
			S_MDIV: begin
				if (sts.div_done) begin
					cmd.op  = OP_SET_MINC;
					state_d = S_ADV;
				end
			end
			S_ADV: begin
				cmd.op  = OP_ADVANCE;
				ch_d    = 1'b0;
				state_d = S_RDA;
			end
			S_RDA: begin
				cmd.op  = OP_RD_A;
				state_d = S_RDB;
			end
			S_RDB: begin
				cmd.op  = OP_RD_B;
				state_d = S_INTERP;
			end
			S_INTERP: begin
				cmd.op  = OP_INTERP;
				state_d = S_FBMUL;
			end
			S_FBMUL: begin
				cmd.op  = OP_FBMUL;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				cmd.op  = OP_WRITE;
				state_d = S_MIX;
			end
			S_MIX: begin
				cmd.op = OP_MIX;
				if (ch_q) begin
					state_d = S_FIN;
				end else begin
					ch_d    = 1'b1;
					state_d = S_RDA;
				end
			end
			S_FIN: begin
				// hold the finished word until the output register frees up
				if (sts.out_free) begin
					cmd.op  = OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = state_q != S_IDLE;

	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == S_DDIV || state_q == S_FDIV || state_q == S_MDIV))
		else $error("divider finished outside a wait state");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_FINISH |-> sts.out_free)
		else $error("result loaded over an untaken word");

	a_mix_after_fb: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MSTART |-> $past(state_q) == S_FDIV)
		else $error("mix division started out of sequence");

endmodule

>>> hdl/sfdl_dp.sv
module sfdl_dp #(
	parameter int RING_DEPTH = sfdl_pkg::RING_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sfdl_pkg::dp_cmd_t               cmd,
	output sfdl_pkg::dp_sts_t               sts,
	input  sfdl_pkg::in_word_t              in_data,
	input  logic                            cfg_valid,
	input  logic [sfdl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfdl_pkg::DTGT_W-1:0]     cfg_data,
	input  logic                            out_stall,
	output logic                            out_valid,
	output sfdl_pkg::out_word_t             out_data
);
	import sfdl_pkg::*;

	localparam int AW  = $clog2(RING_DEPTH);
	localparam int DW  = AW + 8;
	localparam int DLW = DW + 16;
	localparam int QW  = (DLW > LVL_W) ? DLW : LVL_W;
	localparam int TW  = (DW > DTGT_W) ? DW : DTGT_W;
	localparam logic [TW-1:0] DMIN = TW'(256);
	localparam logic [TW-1:0] DTOP = TW'((RING_DEPTH - 2) * 256);
	localparam logic [DW:0]   SPAN = (DW + 1)'(RING_DEPTH * 256);
	localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

	// configuration
	logic [DTGT_W-1:0] dtgt_q;
	logic [15:0]       ftgt_q;
	logic [16:0]       mtgt_q;
	logic [15:0]       dlen_q;
	logic [15:0]       llen_q;

	// smoothers
	logic [DW-1:0]            dgoal_q;
	logic signed [DLW-1:0]    dnow_q;
	logic signed [DLW-1:0]    dinc_q;
	logic [15:0]              dsteps_q;
	logic [15:0]              fgoal_q;
	logic [16:0]              mgoal_q;
	logic signed [LVL_W-1:0]  fnow_q;
	logic signed [LVL_W-1:0]  finc_q;
	logic signed [LVL_W-1:0]  mnow_q;
	logic signed [LVL_W-1:0]  minc_q;
	logic [15:0]              lsteps_q;

	// ring
	logic [SAMPLE_W-1:0] ring_l [RING_DEPTH];
	logic [SAMPLE_W-1:0] ring_r [RING_DEPTH];
	logic [SAMPLE_W-1:0] rd_l_q;
	logic [SAMPLE_W-1:0] rd_r_q;
	logic [AW-1:0]       wp_q;
	logic                full_q;

	// sample path
	in_word_t                   in_q;
	logic [AW-1:0]              second_q;
	logic [7:0]                 frac_q;
	logic                       avld_q;
	logic                       bvld_q;
	logic signed [34:0]         acc_q;
	logic signed [SAMPLE_W-1:0] dly_q;
	logic signed [40:0]         fbp_q;
	logic signed [42:0]         px_q;
	logic signed [SAMPLE_W-1:0] res_l_q;
	logic signed [SAMPLE_W-1:0] res_r_q;
	out_word_t                  out_q;
	logic                       ovld_q;

	// divider
	logic                  div_start;
	logic signed [QW-1:0]  div_num;
	logic [15:0]           div_den;
	logic                  div_done;
	logic signed [QW-1:0]  div_quo;

	logic [TW-1:0]              tgt_w;
	logic [TW-1:0]              dcl_w;
	logic [DW-1:0]              dnew;
	logic [16:0]                mnew;
	logic [15:0]                nd;
	logic [15:0]                nl;
	logic [DW-1:0]              dq;
	logic [DW-1:0]              wp8;
	logic [DW:0]                pos;
	logic [AW-1:0]              first;
	logic [AW-1:0]              second;
	logic [AW-1:0]              rd_addr;
	logic [15:0]                fbg;
	logic [17:0]                mraw;
	logic [17:0]                mg;
	logic signed [SAMPLE_W-1:0] x;
	logic signed [SAMPLE_W-1:0] rdata;
	logic signed [SAMPLE_W-1:0] sa;
	logic signed [SAMPLE_W-1:0] sb;
	logic signed [34:0]         isum;
	logic signed [41:0]         fbr;
	logic signed [43:0]         wsum;
	logic signed [43:0]         msum;
	logic signed [SAMPLE_W-1:0] wdata;

	always_comb begin
		tgt_w = TW'(dtgt_q);
		if (tgt_w < DMIN)
			dcl_w = DMIN;
		else if (tgt_w > DTOP)
			dcl_w = DTOP;
		else
			dcl_w = tgt_w;
		dnew = dcl_w[DW-1:0];
		mnew = (mtgt_q > 17'd65536) ? 17'd65536 : mtgt_q;
		nd   = (dlen_q == 16'd0) ? 16'd1 : dlen_q;
		nl   = (llen_q == 16'd0) ? 16'd1 : llen_q;
	end

	assign sts.delay_chg = dnew != dgoal_q;
	assign sts.level_chg = (ftgt_q != fgoal_q) || (mnew != mgoal_q);
	assign sts.div_done  = div_done;
	assign sts.out_free  = !ovld_q || !out_stall;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = nl;
		case (cmd.op)
			OP_DIV_DELAY: begin
				div_start = 1'b1;
				div_num   = QW'($signed({1'b0, dnew, 15'b0}) - dnow_q);
				div_den   = nd;
			end
			OP_DIV_FB: begin
				div_start = 1'b1;
				div_num   = QW'($signed({1'b0, ftgt_q, 16'b0}) - fnow_q);
				div_den   = nl;
			end
			OP_DIV_MIX: begin
				div_start = 1'b1;
				div_num   = QW'($signed({1'b0, mgoal_q, 15'b0}) - mnow_q);
				div_den   = lsteps_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	sfdl_div #(.QW(QW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// read position behind the write pointer, in 1/256 samples
	always_comb begin
		dq     = dnow_q[DLW-1] ? '0 : dnow_q[DLW-2:15];
		wp8    = {wp_q, 8'b0};
		if (wp8 >= dq)
			pos = {1'b0, wp8} - {1'b0, dq};
		else
			pos = {1'b0, wp8} + SPAN - {1'b0, dq};
		first  = pos[DW-1:8];
		second = (first == LAST) ? '0 : first + 1'b1;
		rd_addr = (cmd.op == OP_RD_A) ? first : second_q;
	end

	always_comb begin
		fbg  = fnow_q[LVL_W-1] ? 16'd0 : fnow_q[31:16];
		mraw = mnow_q[LVL_W-1] ? 18'd0 : mnow_q[32:15];
		mg   = (mraw > 18'd65536) ? 18'd65536 : mraw;
		x     = cmd.ch ? in_q.in_right : in_q.in_left;
		rdata = cmd.ch ? $signed(rd_r_q) : $signed(rd_l_q);
		sa    = avld_q ? rdata : '0;
		sb    = bvld_q ? rdata : '0;
		isum  = acc_q + 35'(sb * $signed({2'b0, frac_q})) + 35'sd128;
		fbr   = 42'(fbp_q) + 42'sd32768;
		wsum  = 44'(x) + 44'(fbr >>> 16);
		wdata = sat24(wsum);
		msum  = 44'(px_q) + 44'(dly_q * $signed({1'b0, mg})) + 44'sd32768;
	end

	always_ff @(posedge clk) begin
		rd_l_q <= ring_l[rd_addr];
		if (cmd.op == OP_WRITE && !cmd.ch)
			ring_l[wp_q] <= wdata;
	end

	always_ff @(posedge clk) begin
		rd_r_q <= ring_r[rd_addr];
		if (cmd.op == OP_WRITE && cmd.ch)
			ring_r[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dtgt_q   <= DTGT_W'(256);
			ftgt_q   <= '0;
			mtgt_q   <= '0;
			dlen_q   <= 16'd4800;
			llen_q   <= 16'd480;
			dgoal_q  <= DW'(256);
			dnow_q   <= $signed({1'b0, DW'(256), 15'b0});
			dinc_q   <= '0;
			dsteps_q <= '0;
			fgoal_q  <= '0;
			mgoal_q  <= '0;
			fnow_q   <= '0;
			finc_q   <= '0;
			mnow_q   <= '0;
			minc_q   <= '0;
			lsteps_q <= '0;
			wp_q     <= '0;
			full_q   <= 1'b0;
			ovld_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_DELAY_TARGET: dtgt_q <= cfg_data;
					REG_FB_TARGET:    ftgt_q <= cfg_data[15:0];
					REG_MIX_TARGET:   mtgt_q <= cfg_data[16:0];
					REG_DELAY_RAMP:   dlen_q <= cfg_data[15:0];
					REG_LEVEL_RAMP:   llen_q <= cfg_data[15:0];
					default: begin
					end
				endcase
			end
			if (ovld_q && !out_stall)
				ovld_q <= 1'b0;
			case (cmd.op)
				OP_DIV_DELAY: begin
					dgoal_q  <= dnew;
					dsteps_q <= nd;
				end
				OP_DIV_FB: begin
					fgoal_q  <= ftgt_q;
					mgoal_q  <= mnew;
					lsteps_q <= nl;
				end
				OP_SET_DINC: dinc_q <= DLW'(div_quo);
				OP_SET_FINC: finc_q <= LVL_W'(div_quo);
				OP_SET_MINC: minc_q <= LVL_W'(div_quo);
				OP_ADVANCE: begin
					if (dsteps_q != 16'd0) begin
						dsteps_q <= dsteps_q - 1'b1;
						if (dsteps_q == 16'd1)
							dnow_q <= $signed({1'b0, dgoal_q, 15'b0});
						else
							dnow_q <= dnow_q + dinc_q;
					end
					if (lsteps_q != 16'd0) begin
						lsteps_q <= lsteps_q - 1'b1;
						if (lsteps_q == 16'd1) begin
							fnow_q <= $signed({1'b0, fgoal_q, 16'b0});
							mnow_q <= $signed({1'b0, mgoal_q, 15'b0});
						end else begin
							fnow_q <= fnow_q + finc_q;
							mnow_q <= mnow_q + minc_q;
						end
					end
				end
				OP_FINISH: begin
					ovld_q <= 1'b1;
					if (wp_q == LAST) begin
						wp_q   <= '0;
						full_q <= 1'b1;
					end else begin
						wp_q <= wp_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD_IN: in_q <= in_data;
			OP_RD_A: begin
				// entries not yet written since reset read as zero
				second_q <= second;
				frac_q   <= pos[7:0];
				avld_q   <= full_q || (first < wp_q);
				bvld_q   <= full_q || (second < wp_q);
			end
			OP_RD_B:   acc_q <= 35'(sa * $signed({1'b0, 9'(9'd256 - {1'b0, frac_q})}));
			OP_INTERP: dly_q <= isum[31:8];
			OP_FBMUL:  fbp_q <= 41'(dly_q * $signed({1'b0, fbg}));
			OP_WRITE:  px_q  <= 43'(x * $signed({1'b0, 18'(18'd65536 - mg)}));
			OP_MIX: begin
				if (cmd.ch)
					res_r_q <= sat24(msum >>> 16);
				else
					res_l_q <= sat24(msum >>> 16);
			end
			OP_FINISH: begin
				out_q.out_left  <= res_l_q;
				out_q.out_right <= res_r_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = ovld_q;
	assign out_data  = out_q;

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= LAST)
		else $error("write pointer beyond ring");

	a_delay_settled: assert property (@(posedge clk) disable iff (!arst_n)
		dsteps_q == 16'd0 |-> dnow_q == $signed({1'b0, dgoal_q, 15'b0}))
		else $error("delay idle away from its goal");

	a_fb_settled: assert property (@(posedge clk) disable iff (!arst_n)
		lsteps_q == 16'd0 |-> fnow_q == $signed({1'b0, fgoal_q, 16'b0}))
		else $error("feedback idle away from its goal");

	a_finish_advances: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_FINISH |=> ovld_q)
		else $error("finished word not presented");

endmodule

>>> hdl/stereo_feedback_delay_line_unit.sv
// Stereo feedback delay with a fractional, linearly interpolated tap.
// Input channel: in_valid / in_stall with one stereo word (in_data). A word is
// taken when in_valid is high and in_stall low; in_stall stays high while a
// word is being worked on, so one word is in flight at a time.
// Output channel: out_valid / out_stall with one stereo result word. The
// result sits in an output register; the next input word is taken while it
// waits. If the receiver stalls, the following result is held inside until
// the register frees, and no further input is taken meanwhile.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects the
// register; indexes beyond the register list are ignored. Write only while idle.
// Sequence: an accepted word is worked on up to out_valid by the sequencer walking
// two channels through two ring reads, five multiplies and a write each; a new
// word is taken only once its result is in the output register.
// A changed delay target adds one division, a changed feedback or mix target two,
// on the bit-serial divider that works out ramp increments (one bit per cycle,
// 41 bits at the default depth).
// Reset: ring reads as silence (entries not written since reset read as zero,
// tracked by the write pointer), registers take their reset values, no clearing
// pass is needed.
module stereo_feedback_delay_line_unit #(
	parameter int RING_DEPTH = sfdl_pkg::RING_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  sfdl_pkg::in_word_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output sfdl_pkg::out_word_t            out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfdl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfdl_pkg::DTGT_W-1:0]    cfg_data
);
	import sfdl_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	sfdl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sfdl_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

>>> dv/stereo_feedback_delay_line_unit_chk.sv
`timescale 1ns / 1ps

module stereo_feedback_delay_line_unit_chk #(
	parameter int RING_DEPTH = sfdl_pkg::RING_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  sfdl_pkg::in_word_t             in_data,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  sfdl_pkg::out_word_t            out_data,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [sfdl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfdl_pkg::DTGT_W-1:0]    cfg_data,
	output int                             mismatches,
	output int                             words_owed
);
	import sfdl_pkg::*;

	localparam longint SAT_HI = 64'sd8388607;
	localparam longint SAT_LO = -64'sd8388608;
	localparam longint WET_FULL = 65536;
	localparam longint DLY_MIN = 256;
	localparam longint DLY_MAX = longint'(RING_DEPTH - 2) << 8;

	// register copies
	bit [24:0] dly_tgt;
	bit [15:0] fb_tgt;
	bit [16:0] mix_tgt;
	bit [15:0] dly_ramp;
	bit [15:0] lvl_ramp;

	// smoother state: delay Q17.23, feedback Q0.32, mix Q1.31
	longint dly_goal, fb_goal, mix_goal;
	longint dly_now, dly_inc, fb_now, fb_inc, mix_now, mix_inc;
	int unsigned dly_left, lvl_left;
	int unsigned wptr;
	longint echo_l [int];
	longint echo_r [int];

	out_word_t out_due [$];

	function automatic longint clip24(longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	function automatic longint echo_get(bit ch, int idx);
		if (ch)
			return echo_r.exists(idx) ? echo_r[idx] : 0;
		return echo_l.exists(idx) ? echo_l[idx] : 0;
	endfunction

	function automatic longint ramp_of(bit [15:0] r);
		return (r == 0) ? 1 : longint'(r);
	endfunction

	// one channel: fractional tap, feedback write, dry/wet blend
	function automatic longint tap_and_blend(bit ch, longint x);
		longint span, d, pos, fr, a, b, dl, g, m, wr;
		int first, second;
		span = longint'(RING_DEPTH) << 8;
		d = (dly_now < 0 ? 64'sd0 : dly_now) >>> 15;
		pos = ((longint'(wptr) << 8) + span - (d % span)) % span;
		first = int'(pos >>> 8) % RING_DEPTH;
		second = (first + 1) % RING_DEPTH;
		fr = pos & 255;
		a = echo_get(ch, first);
		b = echo_get(ch, second);
		dl = (a * (256 - fr) + b * fr + 128) >>> 8;
		g = (fb_now < 0 ? 64'sd0 : fb_now) >>> 16;
		m = (mix_now < 0 ? 64'sd0 : mix_now) >>> 15;
		if (m > WET_FULL)
			m = WET_FULL;
		wr = clip24(x + ((dl * g + 32768) >>> 16));
		if (ch)
			echo_r[int'(wptr)] = wr;
		else
			echo_l[int'(wptr)] = wr;
		return clip24((x * (WET_FULL - m) + dl * m + 32768) >>> 16);
	endfunction

	function automatic out_word_t frame_result(in_word_t w);
		longint d, f, m, n;
		out_word_t r;
		d = longint'(dly_tgt);
		if (d < DLY_MIN)
			d = DLY_MIN;
		if (d > DLY_MAX)
			d = DLY_MAX;
		f = longint'(fb_tgt);
		m = (longint'(mix_tgt) > WET_FULL) ? WET_FULL : longint'(mix_tgt);
		if (d != dly_goal) begin
			n = ramp_of(dly_ramp);
			dly_goal = d;
			dly_inc = ((d << 15) - dly_now) / n;
			dly_left = int'(n);
		end
		if (f != fb_goal || m != mix_goal) begin
			n = ramp_of(lvl_ramp);
			fb_goal = f;
			mix_goal = m;
			fb_inc = ((f << 16) - fb_now) / n;
			mix_inc = ((m << 15) - mix_now) / n;
			lvl_left = int'(n);
		end
		if (dly_left != 0) begin
			dly_now += dly_inc;
			dly_left--;
			if (dly_left == 0)
				dly_now = dly_goal << 15;
		end
		if (lvl_left != 0) begin
			fb_now += fb_inc;
			mix_now += mix_inc;
			lvl_left--;
			if (lvl_left == 0) begin
				fb_now = fb_goal << 16;
				mix_now = mix_goal << 15;
			end
		end
		r.out_left = SAMPLE_W'(tap_and_blend(1'b0, longint'(w.in_left)));
		r.out_right = SAMPLE_W'(tap_and_blend(1'b1, longint'(w.in_right)));
		wptr = (wptr + 1) % RING_DEPTH;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			dly_tgt = 25'd256;
			fb_tgt = '0;
			mix_tgt = '0;
			dly_ramp = 16'd4800;
			lvl_ramp = 16'd480;
			dly_goal = DLY_MIN;
			fb_goal = 0;
			mix_goal = 0;
			dly_now = DLY_MIN << 15;
			dly_inc = 0;
			fb_now = 0;
			fb_inc = 0;
			mix_now = 0;
			mix_inc = 0;
			dly_left = 0;
			lvl_left = 0;
			wptr = 0;
			echo_l.delete();
			echo_r.delete();
			out_due.delete();
			mismatches = 0;
			words_owed = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DELAY_TARGET: dly_tgt = cfg_data;
					REG_FB_TARGET:    fb_tgt = cfg_data[15:0];
					REG_MIX_TARGET:   mix_tgt = cfg_data[16:0];
					REG_DELAY_RAMP:   dly_ramp = cfg_data[15:0];
					REG_LEVEL_RAMP:   lvl_ramp = cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (out_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t: unexpected output word %h", $realtime, out_data);
				end else begin
					want = out_due.pop_front();
					if (want.out_left !== out_data.out_left ||
							want.out_right !== out_data.out_right) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%t: word mismatch L exp %0d got %0d, R exp %0d got %0d",
								$realtime, want.out_left, out_data.out_left,
								want.out_right, out_data.out_right);
					end
				end
			end
			if (in_valid && !in_stall)
				out_due.push_back(frame_result(in_data));
			words_owed = out_due.size();
		end
	end

endmodule

>>> dv/stereo_feedback_delay_line_unit_tb.sv
`timescale 1ns / 1ps

module stereo_feedback_delay_line_unit_tb;
	import sfdl_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
	localparam int CYCLE_LIMIT = 900000;
	localparam int FRAMES_PER_PHASE = 50;
	localparam int PHASES = 9;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_data;
	logic out_valid;
	logic out_stall;
	out_word_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DTGT_W-1:0] cfg_data;

	int mismatches;
	int words_owed;
	int cycles;
	bit hold_req;
	bit calm;

	stereo_feedback_delay_line_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	stereo_feedback_delay_line_unit_chk u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .words_owed(words_owed)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int r;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				repeat (400) @(negedge clk);
				hold_req = 1'b0;
				out_stall = 1'b0;
			end else if (calm) begin
				out_stall = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_stall = 1'b0;
					repeat ($urandom_range(0, 7)) @(negedge clk);
				end else if (r < 95) begin
					out_stall = 1'b1;
					repeat ($urandom_range(0, 2)) @(negedge clk);
				end else begin
					out_stall = 1'b1;
					repeat ($urandom_range(20, 60)) @(negedge clk);
				end
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DTGT_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
		int g;
		in_valid = 1'b1;
		in_data.in_left = l;
		in_data.in_right = r;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		g = $urandom_range(0, 99);
		if (!calm && g >= 50) begin
			in_valid = 1'b0;
			repeat ((g < 93) ? $urandom_range(1, 4) : $urandom_range(20, 80)) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (words_owed != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return SAMPLE_W'($urandom_range(0, 511) - 256);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	function automatic logic [DTGT_W-1:0] pick_delay();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 25'd256;
			3: return 25'((RING_DEPTH_DEF - 2) << 8);
			4: return DTGT_W'($urandom());
			default: return DTGT_W'($urandom_range(256, 300 * 256));
		endcase
	endfunction

	function automatic logic [15:0] pick_ramp();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3: return 16'($urandom());
			default: return 16'($urandom_range(1, 40));
		endcase
	endfunction

	function automatic logic [16:0] pick_mix();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return 17'd65536;
			2: return 17'h1FFFF;
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	initial begin
		logic [15:0] fbv;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_req = 1'b0;
		calm = 1'b0;
		cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// a few words at reset settings, then hard feedback and full wet
		send_frame(24'sh7FFFFF, 24'sh800000);
		send_frame(24'sd0, -24'sd1);
		wait_drained();
		write_reg(REG_DELAY_TARGET, 25'd640);
		write_reg(REG_FB_TARGET, 25'hFFFF);
		write_reg(REG_MIX_TARGET, 25'd65536);
		write_reg(REG_DELAY_RAMP, 25'd1);
		write_reg(REG_LEVEL_RAMP, 25'd1);
		write_reg(REG_SPARE, '1);
		send_frame(24'sh7FFFFF, 24'sh7FFFFF);
		send_frame(24'sh800000, 24'sh800000);
		send_frame(24'sd1, -24'sd1);
		repeat (6) send_frame(24'sh7FFFFF, 24'sh800000);
		send_frame(24'sh555555, 24'shAAAAAA);
		send_frame(24'sd0, 24'sd0);
		wait_drained();
		// clamps: delay below and above range, mix over full wet, zero ramps
		write_reg(REG_DELAY_TARGET, '0);
		write_reg(REG_MIX_TARGET, 25'h1FFFF);
		write_reg(REG_FB_TARGET, 25'd32768);
		write_reg(REG_DELAY_RAMP, '0);
		write_reg(REG_LEVEL_RAMP, '0);
		repeat (4) send_frame(pick_sample(), pick_sample());
		wait_drained();
		write_reg(REG_DELAY_TARGET, '1);
		write_reg(REG_DELAY_RAMP, 25'hFFFF);
		write_reg(REG_LEVEL_RAMP, 25'hFFFF);
		write_reg(REG_FB_TARGET, '0);
		repeat (4) send_frame(pick_sample(), pick_sample());
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			fbv = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
			write_reg(REG_DELAY_TARGET, pick_delay());
			write_reg(REG_FB_TARGET, {9'd0, fbv});
			write_reg(REG_MIX_TARGET, {8'd0, pick_mix()});
			write_reg(REG_DELAY_RAMP, {9'd0, pick_ramp()});
			write_reg(REG_LEVEL_RAMP, {9'd0, pick_ramp()});
			write_reg(3'($urandom_range(5, 7)), DTGT_W'($urandom()));
			calm = (p % 4 == 1);
			if (p == 3)
				hold_req = 1'b1;
			for (int i = 0; i < FRAMES_PER_PHASE; i++) begin
				// words of this phase; targets change only between phases, after draining
				send_frame(pick_sample(), pick_sample());
			end
			calm = 1'b0;
			wait_drained();
		end

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
